### hdl/jkv_pkg.sv
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types, constants and helper functions of the JSON key/value
// extractor: pattern sizes, value and result codes, byte class record.
// ----------------------------------------------------------------------------
package jkv_pkg;

   // Key and pattern sizes (pattern is quote, key bytes, quote)
   localparam int MAX_KEY_BYTES = 8;
   localparam int KEY_W         = 8 * MAX_KEY_BYTES;
   localparam int PAT_W         = MAX_KEY_BYTES + 2;
   localparam int KLEN_W        = 4;

   // Queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_KEY_BYTES  = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd1;
   localparam logic [1:0] CSR_VALUE_KIND = 2'd2;

   // Value kinds
   localparam logic [1:0] VK_STRING = 2'd0;
   localparam logic [1:0] VK_BOOL   = 2'd1;
   localparam logic [1:0] VK_INT    = 2'd2;

   // Result kinds
   localparam logic [1:0] RK_BYTE  = 2'd0;
   localparam logic [1:0] RK_FOUND = 2'd1;
   localparam logic [1:0] RK_MISS  = 2'd2;

   // Characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_U   = 8'h75;
   localparam logic [7:0] CH_LC_E   = 8'h65;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_L   = 8'h6C;
   localparam logic [7:0] CH_LC_S   = 8'h73;

   // Literal lengths
   localparam logic [2:0] LEN_TRUE  = 3'd4;
   localparam logic [2:0] LEN_FALSE = 3'd5;

   // Configuration as seen by front and back
   typedef struct packed {
      logic [KEY_W-1:0]  key_bytes;
      logic [KLEN_W-1:0] key_length;
      logic [1:0]        value_kind;
   } cfg_type;

   // One classified body byte, as it travels through the queue
   typedef struct packed {
      logic [7:0]       byte_val;
      logic             last;
      logic [PAT_W-1:0] mask;
      logic             is_space;
      logic             is_digit;
      logic [3:0]       digit;
      logic             is_quote;
      logic             is_bslash;
      logic             is_colon;
      logic             is_minus;
      logic             is_t;
      logic             is_f;
   } cls_type;

   // Parser phases, one-hot
   typedef enum logic [8:0] {
      PH_SEARCH = 9'b000000001,
      PH_COLON  = 9'b000000010,
      PH_SPACE  = 9'b000000100,
      PH_STR    = 9'b000001000,
      PH_ESC    = 9'b000010000,
      PH_LIT    = 9'b000100000,
      PH_SIGN   = 9'b001000000,
      PH_DIGITS = 9'b010000000,
      PH_DONE   = 9'b100000000
   } phase_type;

   // Key length clamped to the pattern capacity
   function automatic logic [KLEN_W-1:0] clamp_len(input logic [KLEN_W-1:0] klen);
      clamp_len = (klen > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES) : klen;
   endfunction

   // Positions of the quoted key pattern that equal byte c
   function automatic logic [PAT_W-1:0] byte_mask(input logic [7:0]        c,
                                                   input logic [KEY_W-1:0]  kb,
                                                   input logic [KLEN_W-1:0] klen);
      logic [KLEN_W-1:0]  k;
      logic [8*PAT_W-1:0] kext;
      logic [PAT_W-1:0]   m;
      logic [7:0]         p;
      k    = clamp_len(klen);
      kext = {8'h00, kb, 8'h00};
      m    = '0;
      for (int i = 0; i < PAT_W; i++) begin
         if (i == 0 || i == int'(k) + 1) begin
            p = CH_QUOTE;
         end else begin
            p = kext[8*i +: 8];
         end
         if (p == c && i <= int'(k) + 1) begin
            m[i] = 1'b1;
         end
      end
      byte_mask = m;
   endfunction

   // One-hot at the closing quote of the pattern
   function automatic logic [PAT_W-1:0] end_sel(input logic [KLEN_W-1:0] klen);
      end_sel = PAT_W'(1) << (clamp_len(klen) + KLEN_W'(1));
   endfunction

   // Expected character of the true / false literal at a position
   function automatic logic [7:0] lit_char(input logic is_true, input logic [2:0] idx);
      logic [7:0] c;
      unique case ({is_true, idx})
         4'b1000: c = CH_LC_T;
         4'b1001: c = CH_LC_R;
         4'b1010: c = CH_LC_U;
         4'b1011: c = CH_LC_E;
         4'b0000: c = CH_LC_F;
         4'b0001: c = CH_LC_A;
         4'b0010: c = CH_LC_L;
         4'b0011: c = CH_LC_S;
         4'b0100: c = CH_LC_E;
         default: c = 8'h00;
      endcase
      lit_char = c;
   endfunction

endpackage

### hdl/jkv_front.sv
// ----------------------------------------------------------------------------
// jkv_front
// Input side: takes body bytes while the queue has room and classifies each
// one (key pattern mask, whitespace, digit, punctuation).
// ----------------------------------------------------------------------------
module jkv_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_body_byte,
   input  logic             req_body_end,
   input  jkv_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output jkv_pkg::cls_type q_data
);

   // Stall only on a full queue
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Byte classification
   always_comb begin
      q_data           = '0;
      q_data.byte_val  = req_body_byte;
      q_data.last      = req_body_end;
      q_data.mask      = jkv_pkg::byte_mask(req_body_byte, cfg.key_bytes, cfg.key_length);
      q_data.is_space  = (req_body_byte >= jkv_pkg::CH_TAB && req_body_byte <= jkv_pkg::CH_CR)
                         || req_body_byte == jkv_pkg::CH_SPACE;
      q_data.is_digit  = req_body_byte >= jkv_pkg::CH_ZERO && req_body_byte <= jkv_pkg::CH_NINE;
      q_data.digit     = req_body_byte[3:0];
      q_data.is_quote  = req_body_byte == jkv_pkg::CH_QUOTE;
      q_data.is_bslash = req_body_byte == jkv_pkg::CH_BSLASH;
      q_data.is_colon  = req_body_byte == jkv_pkg::CH_COLON;
      q_data.is_minus  = req_body_byte == jkv_pkg::CH_MINUS;
      q_data.is_t      = req_body_byte == jkv_pkg::CH_LC_T;
      q_data.is_f      = req_body_byte == jkv_pkg::CH_LC_F;
   end

endmodule

### hdl/jkv_queue.sv
// ----------------------------------------------------------------------------
// jkv_queue
// Small register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module jkv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jkv_pkg::cls_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jkv_pkg::cls_type head_data
);

   jkv_pkg::cls_type                  entry_ff [jkv_pkg::Q_DEPTH];
   logic [jkv_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jkv_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jkv_pkg::Q_CNT_W-1:0]       count_ff, count_in;

   assign full       = count_ff == jkv_pkg::Q_CNT_W'(jkv_pkg::Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + jkv_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + jkv_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + jkv_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - jkv_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/jkv_back.sv
// ----------------------------------------------------------------------------
// jkv_back
// Parser: key match vector, colon and whitespace skip, value extraction,
// and the registered result stage.
// ----------------------------------------------------------------------------
module jkv_back (
   input  logic                      clock,
   input  logic                      reset,
   input  jkv_pkg::cfg_type          cfg,
   input  logic                      head_valid,
   input  jkv_pkg::cls_type          head_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_result_kind,
   output logic [7:0]                rsp_value_byte,
   output logic                      rsp_bool_value,
   output logic signed [63:0]        rsp_int_value,
   output logic                      rsp_final_res
);

   jkv_pkg::phase_type         phase_ff, phase_in, phase_mid;
   logic [jkv_pkg::PAT_W-1:0]  mv_ff, mv_in, mv_shift;
   logic [2:0]                 prog_ff, prog_in;
   logic                       ltrue_ff, ltrue_in;
   logic [63:0]                acc_ff, acc_in, sdig;
   logic                       neg_ff, neg_in;
   logic [2:0]                 llen;

   logic                       prod;
   logic [1:0]                 o_kind;
   logic [7:0]                 o_byte;
   logic                       o_bool;
   logic [63:0]                o_int;
   logic                       o_fin;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 kind_ff;
   logic [7:0]                 byte_ff;
   logic                       bool_ff;
   logic [63:0]                int_ff;
   logic                       fin_ff;

   // Take the next byte whenever the result stage is free or draining
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   assign mv_shift = ((mv_ff << 1) | jkv_pkg::PAT_W'(1)) & head_data.mask;
   assign llen     = ltrue_ff ? jkv_pkg::LEN_TRUE : jkv_pkg::LEN_FALSE;
   // Digit with the sign applied; accumulator holds the signed value
   assign sdig     = neg_ff ? 64'(0) - {60'b0, head_data.digit} : {60'b0, head_data.digit};

   // One parse step
   always_comb begin
      phase_mid = phase_ff;
      mv_in     = mv_ff;
      prog_in   = prog_ff;
      ltrue_in  = ltrue_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      prod      = 1'b0;
      o_kind    = jkv_pkg::RK_MISS;
      o_byte    = 8'h00;
      o_bool    = 1'b0;
      o_int     = 64'd0;
      o_fin     = 1'b0;

      unique case (phase_ff)
         jkv_pkg::PH_SEARCH: begin
            mv_in = mv_shift;
            if (|(mv_shift & jkv_pkg::end_sel(cfg.key_length))) begin
               mv_in     = '0;
               phase_mid = jkv_pkg::PH_COLON;
            end
         end
         jkv_pkg::PH_COLON: begin
            if (head_data.is_colon) begin
               phase_mid = jkv_pkg::PH_SPACE;
            end
         end
         jkv_pkg::PH_SPACE: begin
            if (!head_data.is_space) begin
               if (cfg.value_kind == jkv_pkg::VK_STRING && head_data.is_quote) begin
                  phase_mid = jkv_pkg::PH_STR;
               end else if (cfg.value_kind == jkv_pkg::VK_BOOL
                            && (head_data.is_t || head_data.is_f)) begin
                  ltrue_in  = head_data.is_t;
                  prog_in   = 3'd1;
                  phase_mid = jkv_pkg::PH_LIT;
               end else if (cfg.value_kind == jkv_pkg::VK_INT && head_data.is_minus) begin
                  neg_in    = 1'b1;
                  phase_mid = jkv_pkg::PH_SIGN;
               end else if (cfg.value_kind == jkv_pkg::VK_INT && head_data.is_digit) begin
                  acc_in    = {60'b0, head_data.digit};
                  phase_mid = jkv_pkg::PH_DIGITS;
               end else begin
                  prod      = 1'b1;
                  o_fin     = 1'b1;
                  phase_mid = jkv_pkg::PH_DONE;
               end
            end
         end
         jkv_pkg::PH_STR: begin
            if (head_data.is_bslash) begin
               phase_mid = jkv_pkg::PH_ESC;
            end else if (head_data.is_quote) begin
               prod      = 1'b1;
               o_kind    = jkv_pkg::RK_FOUND;
               o_fin     = 1'b1;
               phase_mid = jkv_pkg::PH_DONE;
            end else begin
               prod   = 1'b1;
               o_kind = jkv_pkg::RK_BYTE;
               o_byte = head_data.byte_val;
            end
         end
         jkv_pkg::PH_ESC: begin
            phase_mid = jkv_pkg::PH_STR;
            prod      = 1'b1;
            o_kind    = jkv_pkg::RK_BYTE;
            o_byte    = head_data.byte_val;
         end
         jkv_pkg::PH_LIT: begin
            if (prog_ff < llen && head_data.byte_val == jkv_pkg::lit_char(ltrue_ff, prog_ff))
            begin
               prog_in = prog_ff + 3'd1;
               if (prog_ff + 3'd1 == llen) begin
                  prod      = 1'b1;
                  o_kind    = jkv_pkg::RK_FOUND;
                  o_bool    = ltrue_ff;
                  o_fin     = 1'b1;
                  phase_mid = jkv_pkg::PH_DONE;
               end
            end else begin
               prod      = 1'b1;
               o_fin     = 1'b1;
               phase_mid = jkv_pkg::PH_DONE;
            end
         end
         jkv_pkg::PH_SIGN: begin
            if (head_data.is_digit) begin
               acc_in    = 64'(0) - {60'b0, head_data.digit};
               phase_mid = jkv_pkg::PH_DIGITS;
            end else begin
               prod      = 1'b1;
               o_fin     = 1'b1;
               phase_mid = jkv_pkg::PH_DONE;
            end
         end
         jkv_pkg::PH_DIGITS: begin
            if (head_data.is_digit) begin
               // times ten as eight plus two, then the signed digit
               acc_in = (acc_ff << 3) + (acc_ff << 1) + sdig;
            end else begin
               prod      = 1'b1;
               o_kind    = jkv_pkg::RK_FOUND;
               o_int     = acc_ff;
               o_fin     = 1'b1;
               phase_mid = jkv_pkg::PH_DONE;
            end
         end
         jkv_pkg::PH_DONE: begin
         end
         default: begin
            phase_mid = jkv_pkg::PH_SEARCH;
         end
      endcase

      // End of body: close out if undecided, then clear the parse state
      phase_in = phase_mid;
      if (head_data.last) begin
         if (phase_mid == jkv_pkg::PH_DIGITS) begin
            prod   = 1'b1;
            o_kind = jkv_pkg::RK_FOUND;
            o_byte = 8'h00;
            o_bool = 1'b0;
            o_int  = acc_in;
            o_fin  = 1'b1;
         end else if (phase_mid != jkv_pkg::PH_DONE) begin
            prod   = 1'b1;
            o_kind = jkv_pkg::RK_MISS;
            o_byte = 8'h00;
            o_bool = 1'b0;
            o_int  = 64'd0;
            o_fin  = 1'b1;
         end
         phase_in = jkv_pkg::PH_SEARCH;
         mv_in    = '0;
         prog_in  = 3'd0;
         ltrue_in = 1'b0;
         acc_in   = 64'd0;
         neg_in   = 1'b0;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jkv_pkg::PH_SEARCH;
         mv_ff    <= '0;
         prog_ff  <= 3'd0;
         ltrue_ff <= 1'b0;
         acc_ff   <= 64'd0;
         neg_ff   <= 1'b0;
      end else if (pop) begin
         phase_ff <= phase_in;
         mv_ff    <= mv_in;
         prog_ff  <= prog_in;
         ltrue_ff <= ltrue_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
      end
   end

   // Result register
   always_comb begin
      if (pop && prod) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && prod) begin
         kind_ff <= o_kind;
         byte_ff <= o_byte;
         bool_ff <= o_bool;
         int_ff  <= o_int;
         fin_ff  <= o_fin;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_value_byte  = byte_ff;
   assign rsp_bool_value  = bool_ff;
   assign rsp_int_value   = signed'(int_ff);
   assign rsp_final_res   = fin_ff;

endmodule

### hdl/json_key_value_extractor_core.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor_core
// Scans a JSON body for a quoted key and extracts its string, boolean or
// integer value; holds the configuration registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  req_body_byte, req_body_end
//  rsp      out        rsp_valid/rsp_stall  rsp_result_kind, rsp_value_byte,
//                                           rsp_bool_value, rsp_int_value,
//                                           rsp_final_res
//  csr      in         csr_wr_en            csr_index, csr_wdata
//
//  One body byte per cycle sustained while req_stall is low; a transferred
//  byte is written into a queue slot, and once nothing waits ahead of it the
//  slot is read and parsed in the same cycle, then the result is registered.
//  The 64-bit times-ten accumulate in the parser sets the per-byte cycle.
//  A four-entry queue decouples input from parser; req_stall rises only when
//  it is full, so the input runs on while a result waits on rsp_stall.
//  Synchronous active-high reset clears control state and the configuration registers.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_body_byte,
   input  logic                req_body_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic [7:0]          rsp_value_byte,
   output logic                rsp_bool_value,
   output logic signed [63:0]  rsp_int_value,
   output logic                rsp_final_res,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_wdata
);

   jkv_pkg::cfg_type cfg_ff;
   jkv_pkg::cls_type q_in_data, q_head_data;
   logic             q_push, q_full, q_pop, q_head_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            jkv_pkg::CSR_KEY_BYTES:  cfg_ff.key_bytes  <= csr_wdata[jkv_pkg::KEY_W-1:0];
            jkv_pkg::CSR_KEY_LENGTH: cfg_ff.key_length <= csr_wdata[jkv_pkg::KLEN_W-1:0];
            jkv_pkg::CSR_VALUE_KIND: cfg_ff.value_kind <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   jkv_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_body_byte (req_body_byte),
      .req_body_end  (req_body_end),
      .cfg           (cfg_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in_data)
   );

   jkv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   jkv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (q_head_valid),
      .head_data       (q_head_data),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_bool_value  (rsp_bool_value),
      .rsp_int_value   (rsp_int_value),
      .rsp_final_res   (rsp_final_res)
   );

endmodule

### hdl/jkv_checker.sv
// ----------------------------------------------------------------------------
// jkv_checker
// Port-level checks on the result channel of the extractor, bound to the
// top level.
// ----------------------------------------------------------------------------
module jkv_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_result_kind,
   input logic [7:0]         rsp_value_byte,
   input logic               rsp_bool_value,
   input logic signed [63:0] rsp_int_value,
   input logic               rsp_final_res
);

   // Closing result exactly when the kind is found or not found
   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_res == (rsp_result_kind != jkv_pkg::RK_BYTE)))
      else $error("final flag disagrees with result kind");

   // Streamed byte only on string byte results
   a_byte_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != jkv_pkg::RK_BYTE |-> rsp_value_byte == 8'h00)
      else $error("value byte set on a closing result");

   // Boolean and integer values only on a found result
   a_value_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bool_value || rsp_int_value != 64'sd0)
      |-> rsp_result_kind == jkv_pkg::RK_FOUND)
      else $error("value carried by a non-found result");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
      && $stable(rsp_value_byte) && $stable(rsp_int_value))
      else $error("stalled result changed");

endmodule

bind json_key_value_extractor_core jkv_checker u_jkv_checker (.*);
